/* rtl/core/lru_page_replacement_core_assert.svh */
// ----------------------------------------------------------------------------
// LRU page replacement core: assertion macros
// Shared macros for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Check that holds on every clock edge outside reset.
`define LRUPR_ASSERT_CLK(name, prop, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that holds on every clock edge, reset included.
`define LRUPR_ASSERT_ALWAYS(name, prop, msg) \
name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lrupr_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, item and result types shared by the core's modules.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int FRAME_COUNT  = 8;
	localparam int SLOT_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int RANK_W       = SLOT_W;
	localparam int CNT_W        = ($clog2(FRAME_COUNT + 1) > 4) ? $clog2(FRAME_COUNT + 1) : 4;

	localparam int PAGE_W       = 16;
	localparam int FAULT_W      = 16;
	localparam int FRAME_SLOT_W = 3;
	localparam int CFG_W        = 4;

	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
	localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              start_of_sequence;
	} item_t;

	typedef struct packed {
		logic               valid;
		item_t              item;
	} queue_head_t;

	typedef struct packed {
		logic [FAULT_W-1:0]      fault_total;
		logic [PAGE_W-1:0]       evicted_page;
		logic                    evicted_valid;
		logic [FRAME_SLOT_W-1:0] frame_slot;
		logic                    hit;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

/* rtl/core/lru_page_replacement_core.sv */
// A page reference is accepted into a two-item queue and its result is
// registered after the lookup and update phases of the frame table; a
// stalled output holds the update phase. The frame table serves one
// reference at a time, so a new one is not looked up until the last is done.
// Reset is asynchronous and active low; it empties all frames, clears the
// fault count and sets frames_in_use to 8.
// ----------------------------------------------------------------------------
// LRU page replacement core
// Top level: configuration register, front queue and replacement engine.
// ----------------------------------------------------------------------------
module lru_page_replacement_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,  // page_number
	input  logic                              s_tuser,  // start_of_sequence
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit, frame_slot[3], evicted_valid, evicted_page[16], fault_total[16], pad
	output logic [lrupr_pkg::M_TDATA_W-1:0]   m_tdata
);
	import lrupr_pkg::*;

	localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;

	logic [CFG_W-1:0] frames_q;
	queue_head_t      head;
	logic             pop;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? {{(32 - CFG_W){1'b0}}, frames_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_FRAMES_IN_USE)) begin
			frames_q <= pwdata[CFG_W-1:0];
		end
	end

	lrupr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.head     (head),
		.pop      (pop)
	);

	lrupr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.frames_in_use (frames_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule

/* rtl/core/lrupr_front.sv */
// ----------------------------------------------------------------------------
// LRU page replacement front end
// Accepts page references, unpacks them and holds them in a short queue.
// ----------------------------------------------------------------------------
module lrupr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // page_number
	input  logic                        s_tuser,   // start_of_sequence
	output lrupr_pkg::queue_head_t      head,
	input  logic                        pop
);
	import lrupr_pkg::*;

	item_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               do_pop;
	item_t              in_item;

	assign in_item.page_number       = s_tdata;
	assign in_item.start_of_sequence = s_tuser;

	assign s_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/lrupr_back.sv */
// ----------------------------------------------------------------------------
// LRU page replacement back end
// Looks up a reference among the frames, picks the slot and updates ranks.
// ----------------------------------------------------------------------------
module lrupr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lrupr_pkg::queue_head_t            head,
	output logic                              pop,
	input  logic [lrupr_pkg::CFG_W-1:0]       frames_in_use,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lrupr_pkg::M_TDATA_W-1:0]   m_tdata
);
	import lrupr_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOOK = 2'd1;
	localparam logic [1:0] PH_UPD  = 2'd2;

	logic [1:0]              phase_q;
	logic [PAGE_W-1:0]       page_frame_q [FRAME_COUNT];
	logic [FRAME_COUNT-1:0]  occ_q;
	logic [RANK_W-1:0]       rank_q [FRAME_COUNT];
	logic [FAULT_W-1:0]      fault_q;

	logic [PAGE_W-1:0]       page_s1;
	logic                    start_s1;

	logic [PAGE_W-1:0]       page_s2;
	logic                    start_s2;
	logic                    found_s2;
	logic                    evict_s2;
	logic [SLOT_W-1:0]       slot_s2;
	logic [PAGE_W-1:0]       old_page_s2;

	logic                    out_valid_q;
	result_t                 out_q;

	logic                    can_finish;
	logic                    finish;

	logic [CNT_W-1:0]        frames_eff;
	logic [FRAME_COUNT-1:0]  active;
	logic [FRAME_COUNT-1:0]  occ_look;
	logic [FRAME_COUNT-1:0]  hit_vec;
	logic [FRAME_COUNT-1:0]  empty_vec;
	logic [SLOT_W-1:0]       hit_slot;
	logic [SLOT_W-1:0]       empty_slot;
	logic [SLOT_W-1:0]       lru_slot;
	logic [RANK_W-1:0]       lru_rank;
	logic                    look_found;
	logic                    look_empty;
	logic [SLOT_W-1:0]       look_slot;

	logic [FRAME_COUNT-1:0]  occ_e;
	logic [RANK_W-1:0]       rank_e [FRAME_COUNT];
	logic [RANK_W-1:0]       rank_n [FRAME_COUNT];
	logic [FRAME_COUNT-1:0]  occ_n;
	logic                    was_occ;
	logic [RANK_W-1:0]       old_rank;
	logic [FAULT_W-1:0]      fault_e;
	logic [FAULT_W-1:0]      fault_n;

	assign can_finish = !out_valid_q || m_tready;
	assign finish     = (phase_q == PH_UPD) && can_finish;
	assign pop        = head.valid && ((phase_q == PH_IDLE) || finish);

	// Lookup stage: tag compare, first empty frame, least recent frame.
	assign frames_eff = (frames_in_use == '0) ? CNT_W'(1) : CNT_W'(frames_in_use);
	assign occ_look   = start_s1 ? '0 : occ_q;

	always_comb begin
		for (int j = 0; j < FRAME_COUNT; j++) begin
			active[j]    = (CNT_W'(j) < frames_eff);
			hit_vec[j]   = active[j] && occ_look[j] && (page_frame_q[j] == page_s1);
			empty_vec[j] = active[j] && !occ_look[j];
		end
	end

	always_comb begin
		hit_slot   = '0;
		empty_slot = '0;
		for (int j = FRAME_COUNT - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_slot = SLOT_W'(j);
			end
			if (empty_vec[j]) begin
				empty_slot = SLOT_W'(j);
			end
		end
	end

	always_comb begin
		lru_slot = '0;
		lru_rank = start_s1 ? '0 : rank_q[0];
		for (int j = 1; j < FRAME_COUNT; j++) begin
			if (active[j] && !start_s1 && (rank_q[j] > lru_rank)) begin
				lru_slot = SLOT_W'(j);
				lru_rank = rank_q[j];
			end
		end
	end

	assign look_found = |hit_vec;
	assign look_empty = |empty_vec;

	always_comb begin
		priority if (look_found) begin
			look_slot = hit_slot;
		end else if (look_empty) begin
			look_slot = empty_slot;
		end else begin
			look_slot = lru_slot;
		end
	end

	// Update stage: recency ranks, occupancy, fault count.
	assign occ_e   = start_s2 ? '0 : occ_q;
	assign fault_e = start_s2 ? '0 : fault_q;
	assign was_occ = occ_e[slot_s2];

	always_comb begin
		for (int j = 0; j < FRAME_COUNT; j++) begin
			rank_e[j] = start_s2 ? '0 : rank_q[j];
		end
	end

	assign old_rank = rank_e[slot_s2];

	always_comb begin
		for (int j = 0; j < FRAME_COUNT; j++) begin
			if (SLOT_W'(j) == slot_s2) begin
				rank_n[j] = '0;
			end else if (occ_e[j] && (!was_occ || (rank_e[j] < old_rank))) begin
				rank_n[j] = RANK_W'(rank_e[j] + 1'b1);
			end else begin
				rank_n[j] = rank_e[j];
			end
		end
		occ_n          = occ_e;
		occ_n[slot_s2] = 1'b1;
	end

	always_comb begin
		if (found_s2 || (fault_e == FAULT_MAX)) begin
			fault_n = fault_e;
		end else begin
			fault_n = fault_e + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			occ_q       <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < FRAME_COUNT; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: phase_q <= pop ? PH_LOOK : PH_IDLE;
				PH_LOOK: phase_q <= PH_UPD;
				PH_UPD:  phase_q <= can_finish ? (pop ? PH_LOOK : PH_IDLE) : PH_UPD;
				default: phase_q <= PH_IDLE;
			endcase
			if (finish) begin
				occ_q   <= occ_n;
				fault_q <= fault_n;
				for (int j = 0; j < FRAME_COUNT; j++) begin
					rank_q[j] <= rank_n[j];
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			page_s1  <= head.item.page_number;
			start_s1 <= head.item.start_of_sequence;
		end
		if (phase_q == PH_LOOK) begin
			page_s2     <= page_s1;
			start_s2    <= start_s1;
			found_s2    <= look_found;
			evict_s2    <= !look_found && !look_empty;
			slot_s2     <= look_slot;
			old_page_s2 <= page_frame_q[lru_slot];
		end
		if (finish && !found_s2) begin
			page_frame_q[slot_s2] <= page_s2;
		end
		if (finish) begin
			out_q.hit           <= found_s2;
			out_q.frame_slot    <= FRAME_SLOT_W'(slot_s2);
			out_q.evicted_valid <= evict_s2;
			out_q.evicted_page  <= evict_s2 ? old_page_s2 : '0;
			out_q.fault_total   <= fault_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_q);

endmodule

/* rtl/core/lrupr_checker.sv */
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_core_assert.svh"

module lrupr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [lrupr_pkg::M_TDATA_W-1:0]   m_tdata
);
	import lrupr_pkg::*;

	`LRUPR_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !m_tvalid, "result valid during reset")
	`LRUPR_ASSERT_CLK(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`LRUPR_ASSERT_CLK(a_hit_no_evict, m_tvalid && m_tdata[0] |-> !m_tdata[4], "hit reported with eviction")
	`LRUPR_ASSERT_CLK(a_no_evict_zero_page, m_tvalid && !m_tdata[4] |-> m_tdata[20:5] == 16'd0, "evicted page set without eviction")
	`LRUPR_ASSERT_CLK(a_fault_moves_on_miss, m_tvalid && m_tready && !m_tdata[0] |-> m_tdata[36:21] != 16'd0, "miss with zero fault total")

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
